@@ hw/rtl/ffea_pkg.sv @@
// Package for the first-fit extent allocator: widths, status codes, cell types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffea_pkg;
    localparam int AddrBits   = 32;
    localparam int ChunkShift = 5;
    localparam int MaxExtents = 64;
    localparam int ChunkBits  = AddrBits - ChunkShift;   // start chunk width
    localparam int LenBits    = ChunkBits + 1;           // length width
    localparam int CntBits    = $clog2(MaxExtents + 1);

    typedef logic [2:0] t_status;
    localparam t_status StOk       = 3'd0;
    localparam t_status StNoFit    = 3'd1;
    localparam t_status StZeroAll  = 3'd2;
    localparam t_status StNullFree = 3'd3;
    localparam t_status StBadFree  = 3'd4;
    localparam t_status StFull     = 3'd5;

    typedef logic [ChunkBits-1:0] t_start;
    typedef logic [LenBits-1:0]   t_len;

    // Command broadcast to every cell in the apply cycle.
    typedef enum logic [3:0] {
        CMD_NONE   = 4'b0001,
        CMD_SHL    = 4'b0010,   // remove at pos: cells > pos take right neighbor
        CMD_SHR    = 4'b0100,   // insert at pos: cells > pos take left neighbor
        CMD_WRITE  = 4'b1000    // write only at pos
    } t_cmd;

    typedef struct packed {
        t_cmd   cmd;
        logic [CntBits-1:0] pos;
        logic   wr_start;       // write start at pos
        t_start start_val;
        logic   wr_len;
        t_len   len_val;
    } t_ctl;

    // What each cell reports upward for the decision.
    typedef struct packed {
        logic fits;     // valid and length >= request
        logic le;       // valid and start <= c
    } t_flag;
endpackage
`default_nettype wire

@@ hw/rtl/ffea_if.sv @@
// Valid/ready channel interfaces for the allocator's request and response.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ffea_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] address;
    logic [31:0] byte_size;
    modport source (output valid, operation, address, byte_size, input ready);
    modport sink   (input valid, operation, address, byte_size, output ready);
endinterface

interface ffea_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [2:0]  status;
    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ffea_cell.sv @@
// One extent cell: holds a start and length, compares against the request,
// and shifts with its neighbors. Uses ffea_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffea_cell (
    input  wire                     i_clk,
    input  wire  [ffea_pkg::CntBits-1:0] i_idx,
    input  wire  [ffea_pkg::CntBits-1:0] i_count,
    input  wire  ffea_pkg::t_ctl    i_ctl,
    input  wire  ffea_pkg::t_start  i_c,
    input  wire  ffea_pkg::t_len    i_n,
    input  wire  ffea_pkg::t_start  i_left_start,
    input  wire  ffea_pkg::t_len    i_left_len,
    input  wire  ffea_pkg::t_start  i_right_start,
    input  wire  ffea_pkg::t_len    i_right_len,
    output ffea_pkg::t_start        o_start,
    output ffea_pkg::t_len          o_len,
    output ffea_pkg::t_flag         o_flag
);
    import ffea_pkg::*;
    t_start r_start;
    t_len   r_len;
    logic   w_valid;

    assign w_valid = i_idx < i_count;
    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_flag.fits = w_valid && (r_len >= i_n);
    assign o_flag.le   = w_valid && (r_start <= i_c);

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            CMD_SHL: begin
                if (i_idx > i_ctl.pos) begin
                    r_start <= i_right_start;
                    r_len   <= i_right_len;
                end
            end
            CMD_SHR: begin
                if (i_idx > i_ctl.pos) begin
                    r_start <= i_left_start;
                    r_len   <= i_left_len;
                end
            end
            default: ;
        endcase
        if (i_idx == i_ctl.pos && i_ctl.cmd != CMD_NONE) begin
            if (i_ctl.wr_start) r_start <= i_ctl.start_val;
            if (i_ctl.wr_len)   r_len   <= i_ctl.len_val;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/first_fit_extent_allocator.sv @@
// First-fit extent allocator with coalescing, built as a chain of extent cells.
// The request passes search, read neighbors and apply in turn before the response
// is valid (decode happens at the accept edge); a new request is accepted only after
// the response is taken, so any output wait holds off the next request.
// The cell row compares all extents at once; the shift moves every cell together.
// Reset (i_rst_n low, synchronous) empties the table; cell contents are not cleared.
// Uses ffea_pkg, ffea_if and ffea_cell.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_extent_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ffea_req_if.sink   i_req,
    ffea_rsp_if.source o_rsp
);
    import ffea_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_READ   = 5'b00100,
        S_APPLY  = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    logic [CntBits-1:0] r_count;
    logic        r_op;
    logic        r_pre_bad;     // status settled at decode
    t_status     r_pre_st;
    t_start      r_c;
    t_len        r_n;
    logic [CntBits-1:0] r_pos;
    logic        r_found;
    t_start      r_ps, r_ns;    // neighbor starts (prev, next or hit)
    t_len        r_pl, r_nl;
    logic [31:0] r_blk;
    t_status     r_st;
    logic        r_ovalid;
    t_ctl        w_ctl;

    t_start w_start [MaxExtents];
    t_len   w_len   [MaxExtents];
    t_flag  w_flag  [MaxExtents];

    genvar g;
    generate
        for (g = 0; g < MaxExtents; g++) begin : g_cell
            ffea_cell u_cell (
                .i_clk        (i_clk),
                .i_idx        (CntBits'(g)),
                .i_count      (r_count),
                .i_ctl        (w_ctl),
                .i_c          (r_c),
                .i_n          (r_n),
                .i_left_start (w_start[(g == 0) ? 0 : g - 1]),
                .i_left_len   (w_len[(g == 0) ? 0 : g - 1]),
                .i_right_start(w_start[(g == MaxExtents - 1) ? g : g + 1]),
                .i_right_len  (w_len[(g == MaxExtents - 1) ? g : g + 1]),
                .o_start      (w_start[g]),
                .o_len        (w_len[g]),
                .o_flag       (w_flag[g])
            );
        end
    endgenerate

    // Search results: highest fitting cell and number of starts <= c.
    logic [CntBits-1:0] w_hit, w_le;
    logic               w_any;
    always_comb begin
        w_hit = '0;
        w_any = 1'b0;
        w_le  = '0;
        for (int i = 0; i < MaxExtents; i++) begin
            if (w_flag[i].fits) begin
                w_hit = CntBits'(i);
                w_any = 1'b1;
            end
            if (w_flag[i].le) w_le = CntBits'(i + 1);
        end
    end

    // Decode: chunk count and address checks.
    logic [32:0] w_nsum;
    t_len        w_nreq;
    logic [32:0] w_end;
    assign w_nsum = {1'b0, i_req.byte_size} + 33'((1 << ChunkShift) - 1);
    assign w_nreq = t_len'(w_nsum >> ChunkShift);
    assign w_end  = 33'(i_req.address >> ChunkShift) + 33'(w_nreq);

    // Apply-stage decision.
    logic   w_hp, w_hn, w_mp, w_mn, w_ovl;
    logic [LenBits:0] w_pend;
    logic [LenBits:0] w_cend;
    t_len   w_left;
    assign w_hp   = r_pos != '0;
    assign w_hn   = r_pos < r_count;
    assign w_pend = (LenBits+1)'(r_ps) + (LenBits+1)'(r_pl);
    assign w_cend = (LenBits+1)'(r_c) + (LenBits+1)'(r_n);
    assign w_mp   = w_hp && w_pend == (LenBits+1)'(r_c);
    assign w_mn   = w_hn && w_cend == (LenBits+1)'(r_ns);
    assign w_ovl  = (w_hp && w_pend > (LenBits+1)'(r_c)) ||
                    (w_hn && w_cend > (LenBits+1)'(r_ns));
    assign w_left = r_nl - r_n;

    logic [LenBits:0] w_sum3;
    assign w_sum3 = (LenBits+1)'(r_pl) + (LenBits+1)'(r_n) + (LenBits+1)'(r_nl);

    t_status w_st;
    logic [31:0] w_blk;
    logic [CntBits-1:0] n_count;
    always_comb begin
        w_ctl = '{cmd: CMD_NONE, pos: r_pos, wr_start: 1'b0, start_val: r_c,
                  wr_len: 1'b0, len_val: r_n};
        w_st    = r_pre_st;
        w_blk   = '0;
        n_count = r_count;
        if (r_state == S_APPLY && !r_pre_bad) begin
            if (!r_op) begin
                if (!r_found) w_st = StNoFit;
                else begin
                    w_st  = StOk;
                    // Widen before the shift so the top address bits survive.
                    w_blk = 32'(t_len'(r_ns) + w_left) << ChunkShift;
                    if (w_left == '0) begin
                        w_ctl.cmd = CMD_SHL;
                        w_ctl.wr_start = 1'b1;
                        w_ctl.start_val = (r_pos == CntBits'(MaxExtents - 1)) ? r_ns :
                                          w_start[r_pos[$clog2(MaxExtents)-1:0] + 1'b1];
                        w_ctl.wr_len = 1'b1;
                        w_ctl.len_val = (r_pos == CntBits'(MaxExtents - 1)) ? r_nl :
                                        w_len[r_pos[$clog2(MaxExtents)-1:0] + 1'b1];
                        n_count = r_count - 1'b1;
                    end else begin
                        w_ctl.cmd = CMD_WRITE;
                        w_ctl.wr_len = 1'b1;
                        w_ctl.len_val = w_left;
                    end
                end
            end else if (w_ovl) begin
                w_st = StBadFree;
            end else if (w_mp && w_mn) begin
                w_st = StOk;
                // Merge into prev, then pull the rest left over next.
                w_ctl.cmd = CMD_SHL;
                w_ctl.pos = r_pos - 1'b1;
                w_ctl.wr_len = 1'b1;
                w_ctl.len_val = t_len'(w_sum3);
                n_count = r_count - 1'b1;
            end else if (w_mp) begin
                w_st = StOk;
                w_ctl.cmd = CMD_WRITE;
                w_ctl.pos = r_pos - 1'b1;
                w_ctl.wr_len = 1'b1;
                w_ctl.len_val = t_len'(w_pend[LenBits-1:0] - t_len'(r_ps)) + r_n;
            end else if (w_mn) begin
                w_st = StOk;
                w_ctl.cmd = CMD_WRITE;
                w_ctl.wr_start = 1'b1;
                w_ctl.wr_len = 1'b1;
                w_ctl.len_val = r_n + r_nl;
            end else if (r_count >= CntBits'(MaxExtents)) begin
                w_st = StFull;
            end else begin
                w_st = StOk;
                w_ctl.cmd = CMD_SHR;
                w_ctl.wr_start = 1'b1;
                w_ctl.wr_len = 1'b1;
                n_count = r_count + 1'b1;
            end
        end
    end

    // A merge-both shift must skip cell pos-1 itself; cells > pos-1 take right.
    // Cell at pos-1 gets new length via write, which the cell applies after shift.

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.block_address = r_blk;
    assign o_rsp.status        = r_st;

    logic [$clog2(MaxExtents)-1:0] w_pi, w_ni;
    assign w_pi = w_le[$clog2(MaxExtents)-1:0] - 1'b1;
    assign w_ni = w_le[$clog2(MaxExtents)-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        // Latch the request and settle the early statuses.
                        r_op      <= i_req.operation;
                        r_c       <= t_start'(i_req.address >> ChunkShift);
                        r_n       <= w_nreq;
                        if (!i_req.operation) begin
                            r_pre_st  <= StZeroAll;
                            r_pre_bad <= i_req.byte_size == '0;
                        end else if (i_req.address == '0) begin
                            r_pre_st  <= StNullFree;
                            r_pre_bad <= 1'b1;
                        end else if (i_req.address[ChunkShift-1:0] != '0 ||
                                     i_req.byte_size == '0 ||
                                     w_end > 33'(1 << ChunkBits)) begin
                            r_pre_st  <= StBadFree;
                            r_pre_bad <= 1'b1;
                        end else begin
                            r_pre_bad <= 1'b0;
                        end
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_found <= w_any;
                    r_pos   <= r_op ? w_le : w_hit;
                    r_state <= S_READ;
                end
                S_READ: begin
                    // Fetch neighbors: prev at pos-1, next (or the hit) at pos.
                    r_ps <= w_start[w_pi];
                    r_pl <= w_len[w_pi];
                    if (r_op && r_pos == CntBits'(MaxExtents)) begin
                        r_ns <= '0;
                        r_nl <= '0;
                    end else begin
                        r_ns <= w_start[r_op ? w_ni : r_pos[$clog2(MaxExtents)-1:0]];
                        r_nl <= w_len[r_op ? w_ni : r_pos[$clog2(MaxExtents)-1:0]];
                    end
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_count  <= n_count;
                    r_blk    <= w_blk;
                    r_st     <= w_st;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_first_fit_extent_allocator.sv @@
// Testbench for first_fit_extent_allocator: directed table, then random mixed
// allocate/free traffic checked against a behavioral free-extent table.
// Depends on ffea_pkg, ffea_if and the allocator RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_extent_allocator;
    import ffea_pkg::*;

    localparam int ClkHalf   = 6;
    localparam int CycleCap  = 400000;
    localparam int NumRandom = 1050;
    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    typedef struct {
        logic        op;
        logic [31:0] addr;
        logic [31:0] size;
        logic        known;      // expected result typed in below
        logic [31:0] exp_addr;
        t_status     exp_st;
    } t_row;

    typedef struct {
        logic [31:0] addr;
        t_status     st;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    ffea_req_if req_if ();
    ffea_rsp_if rsp_if ();

    first_fit_extent_allocator i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // Behavioral free-extent table, sorted by ascending start chunk.
    longint unsigned ext_start[$];
    longint unsigned ext_len[$];
    t_grant grant_q[$];
    int fail_cnt = 0;
    int cycles = 0;
    bit quiet_rsp = 0;
    bit quiet_req = 0;

    function automatic t_grant predict_grant(logic op, logic [31:0] a, logic [31:0] s);
        t_grant g;
        longint unsigned c, n, pend;
        int pos;
        bit hp, hn, mp, mn;
        g.addr = '0;
        n = (longint'(s) + (1 << ChunkShift) - 1) >> ChunkShift;
        if (op == OpAlloc) begin
            if (s == 0) begin
                g.st = StZeroAll;
                return g;
            end
            for (int k = ext_start.size() - 1; k >= 0; k--) begin
                if (ext_len[k] >= n) begin
                    ext_len[k] -= n;
                    g.addr = 32'((ext_start[k] + ext_len[k]) << ChunkShift);
                    g.st = StOk;
                    if (ext_len[k] == 0) begin
                        ext_start.delete(k);
                        ext_len.delete(k);
                    end
                    return g;
                end
            end
            g.st = StNoFit;
            return g;
        end
        if (a == 0) begin
            g.st = StNullFree;
            return g;
        end
        g.st = StBadFree;
        if (a[ChunkShift-1:0] != 0 || s == 0) return g;
        c = a >> ChunkShift;
        if (c + n > (64'd1 << ChunkBits)) return g;
        pos = 0;
        while (pos < ext_start.size() && ext_start[pos] <= c) pos++;
        hp = pos > 0;
        hn = pos < ext_start.size();
        pend = hp ? ext_start[pos-1] + ext_len[pos-1] : 0;
        if (hp && pend > c) return g;
        if (hn && c + n > ext_start[pos]) return g;
        mp = hp && pend == c;
        mn = hn && c + n == ext_start[pos];
        g.st = StOk;
        if (mp && mn) begin
            ext_len[pos-1] += n + ext_len[pos];
            ext_start.delete(pos);
            ext_len.delete(pos);
        end else if (mp) begin
            ext_len[pos-1] += n;
        end else if (mn) begin
            ext_start[pos] = c;
            ext_len[pos] += n;
        end else if (ext_start.size() >= MaxExtents) begin
            g.st = StFull;
        end else begin
            ext_start.insert(pos, c);
            ext_len.insert(pos, n);
        end
        return g;
    endfunction

    // Sink side: random stall, compare every accepted response.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= quiet_rsp || ($urandom_range(99) >= 22);
            if (rsp_if.valid && rsp_if.ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected response addr=%h st=%0d", $time,
                             rsp_if.block_address, rsp_if.status);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    if (grant_q[0].addr !== rsp_if.block_address
                            || grant_q[0].st !== rsp_if.status) begin
                        $display("%0t: mismatch expected addr=%h st=%0d actual addr=%h st=%0d",
                                 $time, grant_q[0].addr, grant_q[0].st,
                                 rsp_if.block_address, rsp_if.status);
                        fail_cnt <= fail_cnt + 1;
                    end
                    void'(grant_q.pop_front());
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycles > CycleCap) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one request: optional idle gap, hold valid until accepted.
    // Valid drops only while idling, so back-to-back requests keep it high.
    task automatic send_request(logic op, logic [31:0] a, logic [31:0] s,
                                logic known, logic [31:0] ea, t_status es);
        t_grant g;
        while (!quiet_req && $urandom_range(99) < 22) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.address   <= a;
        req_if.byte_size <= s;
        do @(posedge i_clk); while (!req_if.ready);
        g = predict_grant(op, a, s);
        if (known && (g.addr !== ea || g.st !== es)) begin
            $display("%0t: table row disagrees, expected addr=%h st=%0d predicted addr=%h st=%0d",
                     $time, ea, es, g.addr, g.st);
            fail_cnt++;
        end
        grant_q.push_back(g);
    endtask

    t_row rows[$];
    // Pool of allocated blocks for freeing back.
    logic [31:0] held_addr[$];
    logic [31:0] held_size[$];

    function automatic t_row mk(logic op, logic [31:0] a, logic [31:0] s,
                                logic k, logic [31:0] ea, t_status es);
        t_row r;
        r.op = op; r.addr = a; r.size = s; r.known = k; r.exp_addr = ea; r.exp_st = es;
        return r;
    endfunction

    initial begin
        t_grant g;
        int pick;
        logic [31:0] a, s;
        req_if.valid     = 1'b0;
        req_if.operation = 1'b0;
        req_if.address   = '0;
        req_if.byte_size = '0;
        rsp_if.ready     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty table, extremes, each error path, merges.
        rows.push_back(mk(OpAlloc, 0, 32'd1, 1, 0, StNoFit));
        rows.push_back(mk(OpAlloc, 0, 32'd0, 1, 0, StZeroAll));
        rows.push_back(mk(OpFree, 32'd0, 32'd64, 1, 0, StNullFree));
        rows.push_back(mk(OpFree, 32'h0000_1001, 32'd64, 1, 0, StBadFree));
        rows.push_back(mk(OpFree, 32'h0000_1000, 32'd0, 1, 0, StBadFree));
        rows.push_back(mk(OpFree, 32'hFFFF_FFE0, 32'd64, 1, 0, StBadFree));
        rows.push_back(mk(OpFree, 32'hFFFF_FFE0, 32'd32, 1, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_1000, 32'h100, 1, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_1080, 32'd1, 1, 0, StBadFree));
        rows.push_back(mk(OpFree, 32'h0000_0FE0, 32'd64, 1, 0, StBadFree));
        rows.push_back(mk(OpFree, 32'h0000_1100, 32'h100, 0, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_1300, 32'h100, 0, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_1200, 32'h100, 0, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_0F00, 32'h100, 0, 0, StOk));
        rows.push_back(mk(OpAlloc, 0, 32'd1, 1, 32'hFFFF_FFE0, StOk));
        rows.push_back(mk(OpAlloc, 0, 32'hFFFF_FFFF, 1, 0, StNoFit));
        rows.push_back(mk(OpAlloc, 0, 32'd33, 0, 0, StOk));
        rows.push_back(mk(OpAlloc, 0, 32'h500, 0, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0000_0020, 32'hFFFF_FFC0, 0, 0, StOk));
        rows.push_back(mk(OpAlloc, 0, 32'hFFFF_FFE0, 0, 0, StOk));
        rows.push_back(mk(OpAlloc, 0, 32'hFFFF_FFFF, 0, 0, StOk));
        // Fill the table with isolated extents, then overflow it.
        for (int k = 0; k < MaxExtents + 1; k++)
            rows.push_back(mk(OpFree, 32'h0100_0000 + k * 128, 32'd32, 0, 0, StOk));
        rows.push_back(mk(OpFree, 32'h0100_0000 + 32, 32'd32, 0, 0, StOk));
        foreach (rows[i])
            send_request(rows[i].op, rows[i].addr, rows[i].size,
                         rows[i].known, rows[i].exp_addr, rows[i].exp_st);

        // Random part: allocations, free-backs of real allocations, fresh ranges, random frees.
        for (int i = 0; i < NumRandom; i++) begin
            quiet_req = (i >= 400 && i < 550);
            quiet_rsp = (i >= 450 && i < 600);
            pick = $urandom_range(99);
            if (pick < 40) begin
                s = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
                send_request(OpAlloc, $urandom, s, 0, 0, StOk);
                g = grant_q[$];
                if (g.st == StOk) begin
                    held_addr.push_back(g.addr);
                    held_size.push_back(s);
                end
            end else if (pick < 75 && held_addr.size() > 0) begin
                pick = $urandom_range(held_addr.size() - 1);
                send_request(OpFree, held_addr[pick], held_size[pick], 0, 0, StOk);
                held_addr.delete(pick);
                held_size.delete(pick);
            end else if (pick < 90) begin
                a = 32'({$urandom_range(32'h3FFF), 5'd0} << ($urandom_range(1) * 12));
                send_request(OpFree, a, $urandom_range(2048), 0, 0, StOk);
            end else begin
                send_request(OpFree, $urandom, $urandom, 0, 0, StOk);
            end
        end
        req_if.valid <= 1'b0;
        quiet_req = 0;
        quiet_rsp = 0;

        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
